@@ design/tpfc_pkg.sv @@
// Package for the terrain patch frustum cull block: constants, types, helpers.
// Used by tpfc_plane_cell, tpfc_box_unit and terrain_patch_frustum_cull.
package tpfc_pkg;

  localparam int PatchesPerSide = 16;
  localparam int NumPlanes      = 6;

  localparam logic [2:0] RegPlaneBottom = 3'd2;
  localparam logic [2:0] RegScalePad    = 3'd6;
  localparam logic [2:0] RegRadius      = 3'd7;

  // Footprint edge floor((i << 16) / N) for i in 0..N, in Q1.16 (17 bits).
  function automatic logic [16:0] edge_q16(input logic [8:0] i);
    logic [24:0] num;
    begin
      num = {i, 16'd0};
      edge_q16 = 17'((num / 25'(PatchesPerSide)));
    end
  endfunction

  // Box handed from the box unit into the plane chain.
  typedef struct packed {
    logic signed [31:0] ylo;
    logic signed [31:0] yhi;
    logic [16:0]        x0;
    logic [16:0]        x1;
    logic [16:0]        z0;
    logic [16:0]        z1;
  } box_t;

  // Token moving down the plane chain.
  typedef struct packed {
    logic valid;
    logic pass;
    box_t box;
  } tok_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    begin
      if (v > 66'sd2147483647) sat32 = 32'sh7fffffff;
      else if (v < -66'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
    end
  endfunction

endpackage

@@ design/terrain_patch_frustum_cull.sv @@
// Top level of the terrain patch frustum cull block: grid counters, box unit
// and a chain of six plane cells. Depends on tpfc_pkg, tpfc_box_unit, tpfc_plane_cell.
//
//   channel  dir  width  fields (low bit first)
//   s_axis   in   64     height_min, height_max
//   m_axis   out  40+1   visible, visible_so_far, patch_column, patch_row; grid_done on tlast
//   cfg      in   3+64   wr_en, wr_index, wr_data
//
// One patch at a time. A result reaches m_axis later on a planet than on flat
// terrain; the extra time is the one-bit-a-cycle curvature divider, and every
// result also passes through the registered cells of the plane chain.
// The next patch is taken only after the result enters the output register,
// since s_axis_tready rises as it enters. rst is synchronous; it clears the
// counters and the handshake state and resets the configuration registers.
// A finished result waits in a holding register while the output register is
// full, and the input stays blocked until it moves on.
module terrain_patch_frustum_cull import tpfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // height_min, height_max
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // visible, visible_so_far, patch_column, patch_row, zeros
  output logic        m_axis_tlast,   // grid_done
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [63:0] wr_data
);

  logic [63:0] scale_pad;
  logic [31:0] radius;
  logic [7:0]  col, row, pcol, prow;
  logic [16:0] vcount, res_count;
  logic        busy, small_planet, box_done, res_vis, res_full;
  logic        pend_full, pend_pass, take, vis_now, last_patch;
  logic signed [31:0] hmin, hmax;
  box_t        box;
  tok_t        chain [NumPlanes+1];
  logic        last_c;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_pad <= 64'h1_0000_0000;
      radius    <= '0;
    end else if (wr_en) begin
      if (wr_index == RegScalePad) scale_pad <= wr_data;
      if (wr_index == RegRadius) radius <= wr_data[31:0];
    end
  end

  assign s_axis_tready = ~busy;
  assign small_planet = (radius != '0) && (radius < 32'h0004_0000);

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      hmin <= s_axis_tdata[31:0];
      hmax <= s_axis_tdata[63:32];
    end
  end

  tpfc_box_unit u_box (
    .clk(clk), .rst(rst), .start(s_axis_tvalid && s_axis_tready),
    .hmin(hmin), .hmax(hmax), .col(col), .row(row),
    .scale_pad(scale_pad), .radius(radius), .done(box_done), .box(box)
  );

  // Plane cell chain.
  assign chain[0].valid = box_done;
  assign chain[0].pass  = 1'b1;
  assign chain[0].box   = box;

  for (genvar g = 0; g < NumPlanes; g++) begin : g_cell
    tpfc_plane_cell u_cell (
      .clk(clk), .rst(rst),
      .plane_we(wr_en && (wr_index == 3'(g))),
      .plane_data(wr_data),
      .tok_in(chain[g]), .tok_out(chain[g+1])
    );
  end

  assign last_c     = (col == 8'(PatchesPerSide - 1));
  assign last_patch = last_c && (row == 8'(PatchesPerSide - 1));
  assign vis_now    = small_planet | pend_pass;
  // The held result moves on when the output register is free or being emptied.
  assign take       = pend_full && (!res_full || m_axis_tready);

  // Busy spans the patch until its result enters the output register; then
  // the counters advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; col <= '0; row <= '0; vcount <= '0; res_full <= 1'b0;
      pend_full <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) busy <= 1'b1;
      if (m_axis_tvalid && m_axis_tready) res_full <= 1'b0;
      if (chain[NumPlanes].valid) begin
        pend_full <= 1'b1;
        pend_pass <= chain[NumPlanes].pass;
      end
      if (take) begin
        pend_full <= 1'b0;
        busy <= 1'b0;
        res_full <= 1'b1;
        res_vis <= vis_now;
        pcol <= col;
        prow <= row;
        m_axis_tlast <= last_patch;
        res_count <= vcount + 17'(vis_now);
        if (last_patch) begin
          col <= '0; row <= '0; vcount <= '0;
        end else begin
          vcount <= vcount + 17'(vis_now);
          if (last_c) begin
            col <= '0; row <= row + 8'd1;
          end else col <= col + 8'd1;
        end
      end
    end
  end

  assign m_axis_tvalid = res_full;
  assign m_axis_tdata[0] = res_vis;
  assign m_axis_tdata[17:1] = res_count;
  assign m_axis_tdata[25:18] = pcol;
  assign m_axis_tdata[33:26] = prow;
  assign m_axis_tdata[39:34] = '0;

  // The output slot never fills while no patch is in work.
  a_fill_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(res_full) |-> $past(busy)) else $error("result without patch");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("double accept");
  a_col: assert property (@(posedge clk) disable iff (rst)
    col < 8'(PatchesPerSide) && row < 8'(PatchesPerSide)) else $error("counter range");
  // A finished patch never lands on a held result.
  a_pend: assert property (@(posedge clk) disable iff (rst)
    chain[NumPlanes].valid |-> !pend_full) else $error("held result overwritten");

endmodule

@@ design/tpfc_plane_cell.sv @@
// One plane test cell of the cull chain; it holds its plane and tests the box
// with the positive-vertex rule. Depends on tpfc_pkg.
module tpfc_plane_cell import tpfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        plane_we,
  input  logic [63:0] plane_data,
  input  tok_t        tok_in,
  output tok_t        tok_out
);

  logic [63:0] plane;
  logic signed [15:0] ca, cb, cc, cd;
  logic signed [32:0] vx, vy, vz;
  logic signed [50:0] sum;

  always_ff @(posedge clk) begin
    if (rst) plane <= '0;
    else if (plane_we) plane <= plane_data;
  end

  // Pick the positive vertex and sum the plane equation exactly.
  always_comb begin
    ca = plane[15:0];
    cb = plane[31:16];
    cc = plane[47:32];
    cd = plane[63:48];
    vx = ca[15] ? 33'(signed'({1'b0, tok_in.box.x0})) : 33'(signed'({1'b0, tok_in.box.x1}));
    vy = cb[15] ? 33'(tok_in.box.ylo) : 33'(tok_in.box.yhi);
    vz = cc[15] ? 33'(signed'({1'b0, tok_in.box.z0})) : 33'(signed'({1'b0, tok_in.box.z1}));
    sum = 51'(ca * vx) + 51'(cb * vy) + 51'(cc * vz) + (51'(cd) <<< 16);
  end

  always_ff @(posedge clk) begin
    if (rst) tok_out.valid <= 1'b0;
    else tok_out.valid <= tok_in.valid;
    tok_out.pass <= tok_in.pass & ~sum[50];
    tok_out.box  <= tok_in.box;
  end

endmodule

@@ design/tpfc_box_unit.sv @@
// Builds the patch box: scaling, padding and curvature drops, one step a cycle.
// Depends on tpfc_pkg.
module tpfc_box_unit import tpfc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] hmin,
  input  logic signed [31:0] hmax,
  input  logic [7:0]         col,
  input  logic [7:0]         row,
  input  logic [63:0]        scale_pad,
  input  logic [31:0]        radius,
  output logic               done,
  output box_t               box
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_MUL = 5'b00010, S_DIST = 5'b00100,
    S_DIV = 5'b01000, S_FIN = 5'b10000
  } st_t;

  st_t state;
  logic [5:0]  cnt;
  logic signed [63:0] pmin, pmax;
  logic [33:0] qn, qf, rn, rf;
  logic [32:0] den;
  logic [16:0] x0, x1, z0, z1;
  logic signed [31:0] ylo, yhi;
  logic [15:0] dx, dz, fx, fz;
  logic [34:0] rn_sh, rf_sh;
  logic [33:0] fq;

  assign x0 = edge_q16({1'b0, col});
  assign x1 = edge_q16(9'({1'b0, col}) + 9'd1);
  assign z0 = edge_q16({1'b0, row});
  assign z1 = edge_q16(9'({1'b0, row}) + 9'd1);

  // Distances from the footprint to its center, nearest and farthest.
  always_comb begin
    if (x0 > 17'h8000) dx = 16'(x0 - 17'h8000);
    else if (x1 < 17'h8000) dx = 16'(17'h8000 - x1);
    else dx = '0;
    if (z0 > 17'h8000) dz = 16'(z0 - 17'h8000);
    else if (z1 < 17'h8000) dz = 16'(17'h8000 - z1);
    else dz = '0;
    fx = (x0 + x1 < 17'h10000) ? 16'(17'h8000 - x0) : 16'(x1 - 17'h8000);
    fz = (z0 + z1 < 17'h10000) ? 16'(17'h8000 - z0) : 16'(z1 - 17'h8000);
    rn_sh = {rn, qn[33]};
    rf_sh = {rf, qf[33]};
    fq = qf + 34'((rf != 0) ? 1 : 0);
  end

  // Sequencer: multiply, distances, restoring division (skipped when radius is zero), final saturation.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) state <= S_MUL;
        S_MUL: state <= S_DIST;
        S_DIST: begin
          state <= (radius == '0) ? S_FIN : S_DIV;
          cnt <= '0;
        end
        S_DIV: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd33) state <= S_FIN;
        end
        S_FIN: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_MUL: begin
        pmin <= hmin * $signed(scale_pad[63:32]);
        pmax <= hmax * $signed(scale_pad[63:32]);
      end
      S_DIST: begin
        ylo <= sat32(66'(sat32(66'(pmin >>> 16))) - 66'($signed(scale_pad[31:0])));
        yhi <= sat32(66'(sat32(66'(pmax >>> 16))) + 66'($signed(scale_pad[31:0])));
        den <= {radius, 1'b0};
        qn <= 34'(dx * dx) + 34'(dz * dz);
        qf <= 34'(fx * fx) + 34'(fz * fz);
        rn <= '0;
        rf <= '0;
      end
      S_DIV: begin
        if (rn_sh >= 35'(den)) begin
          rn <= 34'(rn_sh - 35'(den));
          qn <= {qn[32:0], 1'b1};
        end else begin
          rn <= 34'(rn_sh);
          qn <= {qn[32:0], 1'b0};
        end
        if (rf_sh >= 35'(den)) begin
          rf <= 34'(rf_sh - 35'(den));
          qf <= {qf[32:0], 1'b1};
        end else begin
          rf <= 34'(rf_sh);
          qf <= {qf[32:0], 1'b0};
        end
      end
      S_FIN: begin
        box.x0 <= x0; box.x1 <= x1; box.z0 <= z0; box.z1 <= z1;
        if (radius != '0) begin
          box.yhi <= sat32(66'(yhi) - 66'(qn));
          box.ylo <= sat32(66'(ylo) - 66'(fq));
        end else begin
          box.yhi <= yhi;
          box.ylo <= ylo;
        end
      end
      default: ;
    endcase
  end

endmodule
